/* design/sha512_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and functions of the SHA-512 hash engine.
package sha512_pkg;

	localparam int ROUND_COUNT_DEF = 80;
	localparam int KIDX_W          = 7;
	localparam int WORD_W          = 64;
	localparam int CNT_W           = 61;

	localparam logic [WORD_W-1:0] PAD_MARK = 64'h8000000000000000;

	localparam logic [0:7][WORD_W-1:0] SHA_IV = {
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
		64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	typedef struct packed {
		logic load;   // copy chaining words into working words
		logic step;   // run one round
		logic fold;   // add working words into chaining words
		logic init;   // restore the initial hash words
	} rnd_ctl_t;

	typedef struct packed {
		logic push;   // shift a message word in
		logic expand; // shift a scheduled word in
	} sch_ctl_t;

	function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
		rotr = (x >> n) | (x << (WORD_W - n));
	endfunction

	function automatic logic [WORD_W-1:0] ssig0(input logic [WORD_W-1:0] x);
		ssig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
	endfunction

	function automatic logic [WORD_W-1:0] ssig1(input logic [WORD_W-1:0] x);
		ssig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
	endfunction

	function automatic logic [WORD_W-1:0] bsig0(input logic [WORD_W-1:0] x);
		bsig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
	endfunction

	function automatic logic [WORD_W-1:0] bsig1(input logic [WORD_W-1:0] x);
		bsig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
	endfunction

	function automatic logic [WORD_W-1:0] k_rom(input logic [KIDX_W-1:0] idx);
		case (idx)
			7'd0:  k_rom = 64'h428a2f98d728ae22;
			7'd1:  k_rom = 64'h7137449123ef65cd;
			7'd2:  k_rom = 64'hb5c0fbcfec4d3b2f;
			7'd3:  k_rom = 64'he9b5dba58189dbbc;
			7'd4:  k_rom = 64'h3956c25bf348b538;
			7'd5:  k_rom = 64'h59f111f1b605d019;
			7'd6:  k_rom = 64'h923f82a4af194f9b;
			7'd7:  k_rom = 64'hab1c5ed5da6d8118;
			7'd8:  k_rom = 64'hd807aa98a3030242;
			7'd9:  k_rom = 64'h12835b0145706fbe;
			7'd10: k_rom = 64'h243185be4ee4b28c;
			7'd11: k_rom = 64'h550c7dc3d5ffb4e2;
			7'd12: k_rom = 64'h72be5d74f27b896f;
			7'd13: k_rom = 64'h80deb1fe3b1696b1;
			7'd14: k_rom = 64'h9bdc06a725c71235;
			7'd15: k_rom = 64'hc19bf174cf692694;
			7'd16: k_rom = 64'he49b69c19ef14ad2;
			7'd17: k_rom = 64'hefbe4786384f25e3;
			7'd18: k_rom = 64'h0fc19dc68b8cd5b5;
			7'd19: k_rom = 64'h240ca1cc77ac9c65;
			7'd20: k_rom = 64'h2de92c6f592b0275;
			7'd21: k_rom = 64'h4a7484aa6ea6e483;
			7'd22: k_rom = 64'h5cb0a9dcbd41fbd4;
			7'd23: k_rom = 64'h76f988da831153b5;
			7'd24: k_rom = 64'h983e5152ee66dfab;
			7'd25: k_rom = 64'ha831c66d2db43210;
			7'd26: k_rom = 64'hb00327c898fb213f;
			7'd27: k_rom = 64'hbf597fc7beef0ee4;
			7'd28: k_rom = 64'hc6e00bf33da88fc2;
			7'd29: k_rom = 64'hd5a79147930aa725;
			7'd30: k_rom = 64'h06ca6351e003826f;
			7'd31: k_rom = 64'h142929670a0e6e70;
			7'd32: k_rom = 64'h27b70a8546d22ffc;
			7'd33: k_rom = 64'h2e1b21385c26c926;
			7'd34: k_rom = 64'h4d2c6dfc5ac42aed;
			7'd35: k_rom = 64'h53380d139d95b3df;
			7'd36: k_rom = 64'h650a73548baf63de;
			7'd37: k_rom = 64'h766a0abb3c77b2a8;
			7'd38: k_rom = 64'h81c2c92e47edaee6;
			7'd39: k_rom = 64'h92722c851482353b;
			7'd40: k_rom = 64'ha2bfe8a14cf10364;
			7'd41: k_rom = 64'ha81a664bbc423001;
			7'd42: k_rom = 64'hc24b8b70d0f89791;
			7'd43: k_rom = 64'hc76c51a30654be30;
			7'd44: k_rom = 64'hd192e819d6ef5218;
			7'd45: k_rom = 64'hd69906245565a910;
			7'd46: k_rom = 64'hf40e35855771202a;
			7'd47: k_rom = 64'h106aa07032bbd1b8;
			7'd48: k_rom = 64'h19a4c116b8d2d0c8;
			7'd49: k_rom = 64'h1e376c085141ab53;
			7'd50: k_rom = 64'h2748774cdf8eeb99;
			7'd51: k_rom = 64'h34b0bcb5e19b48a8;
			7'd52: k_rom = 64'h391c0cb3c5c95a63;
			7'd53: k_rom = 64'h4ed8aa4ae3418acb;
			7'd54: k_rom = 64'h5b9cca4f7763e373;
			7'd55: k_rom = 64'h682e6ff3d6b2b8a3;
			7'd56: k_rom = 64'h748f82ee5defb2fc;
			7'd57: k_rom = 64'h78a5636f43172f60;
			7'd58: k_rom = 64'h84c87814a1f0ab72;
			7'd59: k_rom = 64'h8cc702081a6439ec;
			7'd60: k_rom = 64'h90befffa23631e28;
			7'd61: k_rom = 64'ha4506cebde82bde9;
			7'd62: k_rom = 64'hbef9a3f7b2c67915;
			7'd63: k_rom = 64'hc67178f2e372532b;
			7'd64: k_rom = 64'hca273eceea26619c;
			7'd65: k_rom = 64'hd186b8c721c0c207;
			7'd66: k_rom = 64'heada7dd6cde0eb1e;
			7'd67: k_rom = 64'hf57d4f7fee6ed178;
			7'd68: k_rom = 64'h06f067aa72176fba;
			7'd69: k_rom = 64'h0a637dc5a2c898a6;
			7'd70: k_rom = 64'h113f9804bef90dae;
			7'd71: k_rom = 64'h1b710b35131c471b;
			7'd72: k_rom = 64'h28db77f523047d84;
			7'd73: k_rom = 64'h32caab7b40c72493;
			7'd74: k_rom = 64'h3c9ebe0a15c9bebc;
			7'd75: k_rom = 64'h431d67c49c100d4c;
			7'd76: k_rom = 64'h4cc5d4becb3e42b6;
			7'd77: k_rom = 64'h597f299cfc657e2a;
			7'd78: k_rom = 64'h5fcb6fab3ad6faec;
			7'd79: k_rom = 64'h6c44198c4a475817;
			default: k_rom = '0;
		endcase
	endfunction

endpackage

/* design/sha512_sched.sv */
`timescale 1ns / 1ps
// Block buffer and message schedule as a 16-word shift line.
module sha512_sched
	import sha512_pkg::*;
(
	input  logic              clk,
	input  sch_ctl_t          ctl,
	input  logic [WORD_W-1:0] push_word,
	output logic [WORD_W-1:0] w_cur
);

	logic [WORD_W-1:0] w_q [16];
	logic [WORD_W-1:0] w_next;

	// next schedule word from the fixed taps of the line
	assign w_next = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
	assign w_cur  = w_q[0];

	always_ff @(posedge clk) begin
		if (ctl.push || ctl.expand) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= ctl.push ? push_word : w_next;
		end
	end

endmodule

/* design/sha512_round.sv */
`timescale 1ns / 1ps
// Shared round unit with working words and chaining words.
module sha512_round
	import sha512_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  rnd_ctl_t          ctl,
	input  logic [WORD_W-1:0] k_word,
	input  logic [WORD_W-1:0] w_word,
	input  logic [2:0]        rd_idx,
	output logic [WORD_W-1:0] rd_word
);

	logic [WORD_W-1:0] wv_q [8];
	logic [WORD_W-1:0] cv_q [8];
	logic [WORD_W-1:0] t1;
	logic [WORD_W-1:0] t2;
	logic [WORD_W-1:0] ch;
	logic [WORD_W-1:0] maj;

	assign ch  = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
	assign maj = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
	assign t1  = wv_q[7] + bsig1(wv_q[4]) + ch + k_word + w_word;
	assign t2  = bsig0(wv_q[0]) + maj;

	assign rd_word = cv_q[rd_idx];

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < 8; i++) begin
				wv_q[i] <= cv_q[i];
			end
		end else if (ctl.step) begin
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				cv_q[i] <= SHA_IV[i];
			end
		end else if (ctl.init) begin
			for (int i = 0; i < 8; i++) begin
				cv_q[i] <= SHA_IV[i];
			end
		end else if (ctl.fold) begin
			for (int i = 0; i < 8; i++) begin
				cv_q[i] <= cv_q[i] + wv_q[i];
			end
		end
	end

endmodule

/* design/sha512_hash_engine.sv */
`timescale 1ns / 1ps
// Top level of the SHA-512 hash engine: padding, sequencer and digest output.
//
//  channel  | direction | tdata              | tuser            | tlast
//  s_axis   | in        | data_word [63:0]   | valid_bytes [3:0]| last_word
//  m_axis   | out       | digest_word [63:0] | word_index [2:0] | last_result
//
// A message word enters the block buffer when it is accepted. Every 16th word
// starts a compression: ROUND_COUNT rounds of the single round unit (one
// round a cycle), then a fold of the working words into the chaining words.
// After the last word, padding words go in one a cycle (one or two extra
// compressions), then eight digest transactions follow.
// s_axis_tready is low during padding, compression and digest output.
// m_axis holds its transaction until taken; a stall on it freezes the block.
// Reset restores the initial hash words and clears the byte count.
module sha512_hash_engine
	import sha512_pkg::*;
#(
	parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [WORD_W-1:0] s_axis_tdata,   // [63:0] data_word
	input  logic [3:0]        s_axis_tuser,   // [3:0] valid_bytes
	input  logic              s_axis_tlast,   // last_word
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [WORD_W-1:0] m_axis_tdata,   // [63:0] digest_word
	output logic [2:0]        m_axis_tuser,   // [2:0] word_index
	output logic              m_axis_tlast    // last_result
);

	localparam int RCNT_W = $clog2(ROUND_COUNT);

	localparam logic [2:0] ST_IN   = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_COMP = 3'd2;
	localparam logic [2:0] ST_FOLD = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]        state_q;
	logic [3:0]        fill_q;       // words in the block buffer
	logic [CNT_W-1:0]  cnt_q;        // message bytes, wraps
	logic [RCNT_W-1:0] rnd_q;
	logic [2:0]        idx_q;
	logic              pad_act_q;    // message ended, padding under way
	logic              mark_pend_q;  // 0x80 marker still to be pushed
	logic              len_ok_q;     // length word fits into this block
	logic              final_q;      // length word pushed

	logic              in_acc;
	logic              out_acc;
	logic [3:0]        nb;
	logic [5:0]        sh;
	logic [WORD_W-1:0] keep;
	logic [WORD_W-1:0] in_word;
	logic [WORD_W-1:0] pad_word;
	logic [WORD_W-1:0] push_word;
	logic [WORD_W-1:0] w_cur;
	logic              push;
	logic              blk_full;
	sch_ctl_t          sch_ctl;
	rnd_ctl_t          rnd_ctl;

	assign s_axis_tready = (state_q == ST_IN);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// clamp the byte count, then mask the tail and drop the marker in
	assign nb   = (s_axis_tuser > 4'd8) ? 4'd8 : s_axis_tuser;
	assign sh   = {nb[2:0], 3'b000};
	assign keep = ~({WORD_W{1'b1}} >> sh);
	assign in_word = (!s_axis_tlast || nb[3]) ? s_axis_tdata
	                                         : ((s_axis_tdata & keep) | (PAD_MARK >> sh));

	assign pad_word = mark_pend_q ? PAD_MARK
	                : ((fill_q == 4'd15) && len_ok_q) ? {cnt_q, 3'b000}
	                : '0;

	assign push      = in_acc || (state_q == ST_PAD);
	assign push_word = (state_q == ST_PAD) ? pad_word : in_word;
	assign blk_full  = push && (fill_q == 4'd15);

	assign sch_ctl.push   = push;
	assign sch_ctl.expand = (state_q == ST_COMP);

	assign rnd_ctl.load = blk_full;
	assign rnd_ctl.step = (state_q == ST_COMP);
	assign rnd_ctl.fold = (state_q == ST_FOLD);
	assign rnd_ctl.init = out_acc && (idx_q == 3'd7);

	sha512_sched u_sched (
		.clk       (clk),
		.ctl       (sch_ctl),
		.push_word (push_word),
		.w_cur     (w_cur)
	);

	sha512_round u_round (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (rnd_ctl),
		.k_word  (k_rom(KIDX_W'(rnd_q))),
		.w_word  (w_cur),
		.rd_idx  (idx_q),
		.rd_word (m_axis_tdata)
	);

	assign m_axis_tuser = idx_q;
	assign m_axis_tlast = (idx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IN;
			fill_q      <= '0;
			cnt_q       <= '0;
			rnd_q       <= '0;
			idx_q       <= '0;
			pad_act_q   <= 1'b0;
			mark_pend_q <= 1'b0;
			len_ok_q    <= 1'b0;
			final_q     <= 1'b0;
		end else begin
			if (push) begin
				fill_q <= fill_q + 4'd1;
			end
			case (state_q)
				ST_IN: begin
					if (in_acc) begin
						if (s_axis_tlast) begin
							cnt_q       <= cnt_q + CNT_W'(nb);
							pad_act_q   <= 1'b1;
							mark_pend_q <= nb[3];
							len_ok_q    <= (fill_q <= 4'd13);
						end else begin
							cnt_q <= cnt_q + CNT_W'(8);
						end
						if (fill_q == 4'd15) begin
							state_q <= ST_COMP;
						end else if (s_axis_tlast) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (mark_pend_q) begin
						// marker pushed now: length fits only with two words left
						mark_pend_q <= 1'b0;
						len_ok_q    <= (fill_q <= 4'd13);
					end else if ((fill_q == 4'd15) && len_ok_q) begin
						final_q <= 1'b1;
					end
					if (fill_q == 4'd15) begin
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					if (rnd_q == RCNT_W'(ROUND_COUNT - 1)) begin
						rnd_q   <= '0;
						state_q <= ST_FOLD;
					end else begin
						rnd_q <= rnd_q + RCNT_W'(1);
					end
				end
				ST_FOLD: begin
					// a fresh block always has room for the length
					len_ok_q <= 1'b1;
					if (final_q) begin
						state_q <= ST_OUT;
					end else if (pad_act_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IN;
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							state_q   <= ST_IN;
							cnt_q     <= '0;
							pad_act_q <= 1'b0;
							final_q   <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IN;
				end
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input and output both open");

	a_empty_in_comp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP) |-> (fill_q == 4'd0))
		else $error("block buffer not empty during compression");

	a_rnd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_COMP) |-> (rnd_q == '0))
		else $error("round counter moved outside compression");

	a_out_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && m_axis_tlast) |=> (state_q == ST_IN && cnt_q == '0))
		else $error("engine not back to idle after digest");

	a_out_padded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (final_q && !mark_pend_q && fill_q == 4'd0))
		else $error("digest shown before padding finished");

endmodule

/* bench/sha512_digest_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the SHA-512 hash engine: predicts each digest from the input stream and checks it.
module sha512_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [63:0] data_word
	input  logic [3:0]  s_axis_tuser,   // [3:0] valid_bytes
	input  logic        s_axis_tlast,   // last_word
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,   // [63:0] digest_word
	input  logic [2:0]  m_axis_tuser,   // [2:0] word_index
	input  logic        m_axis_tlast,   // last_result
	output int          fail_count,
	output int          outstanding
);

	typedef struct packed {
		logic [63:0] word;
		logic [2:0]  index;
		logic        closing;
	} digest_beat_t;

	localparam logic [0:7][63:0] START_HASH = {
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
		64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	localparam logic [0:79][63:0] ROUND_K = {
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
		64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
		64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
		64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
		64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
		64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
		64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
		64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
		64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
		64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
		64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
		64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
		64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
		64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
		64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
		64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
		64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
		64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
		64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
		64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
		64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	logic [63:0]  chain [0:7];
	logic [63:0]  block_words [0:15];
	int           fill_count;
	logic [60:0]  byte_total;
	digest_beat_t expected_digest [$];
	digest_beat_t want;

	function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	task automatic restart_hash();
		for (int i = 0; i < 8; i++)
			chain[i] = START_HASH[i];
		fill_count = 0;
		byte_total = '0;
	endtask

	task automatic compress_block();
		logic [63:0] w [0:79];
		logic [63:0] v [0:7];
		logic [63:0] s0, s1, t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = block_words[t];
		for (int t = 16; t < 80; t++) begin
			s0 = ror64(w[t-15], 1) ^ ror64(w[t-15], 8) ^ (w[t-15] >> 7);
			s1 = ror64(w[t-2], 19) ^ ror64(w[t-2], 61) ^ (w[t-2] >> 6);
			w[t] = s1 + w[t-7] + s0 + w[t-16];
		end
		for (int i = 0; i < 8; i++)
			v[i] = chain[i];
		for (int t = 0; t < 80; t++) begin
			t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
			t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] = chain[i] + v[i];
	endtask

	task automatic push_word(input logic [63:0] w);
		block_words[fill_count] = w;
		fill_count++;
		if (fill_count == 16) begin
			compress_block();
			fill_count = 0;
		end
	endtask

	// Absorb one input transaction; a closing word pads the message and queues the digest.
	task automatic absorb_word(input logic [63:0] data, input logic [3:0] nbytes,
			input logic closing);
		int n;
		logic [63:0] keep;
		if (!closing) begin
			push_word(data);
			byte_total = byte_total + 61'd8;
			return;
		end
		n = (nbytes > 4'd8) ? 8 : int'(nbytes);
		byte_total = byte_total + 61'(n);
		if (n == 8) begin
			push_word(data);
			push_word(64'h8000000000000000);
		end else begin
			keep = (n == 0) ? 64'd0 : (~64'd0 << (64 - 8 * n));
			push_word((data & keep) | (64'h80 << (56 - 8 * n)));
		end
		while (fill_count != 14)
			push_word(64'd0);
		push_word(64'd0);
		push_word({byte_total, 3'b000});
		for (int i = 0; i < 8; i++)
			expected_digest.push_back('{chain[i], 3'(i), i == 7});
		restart_hash();
	endtask

	task automatic report_mismatch(input string note);
		$display("%0d ns: %s", $time, note);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_hash();
			expected_digest.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				absorb_word(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_digest.size() == 0) begin
					report_mismatch($sformatf("unexpected digest transaction %h index %0d",
						m_axis_tdata, m_axis_tuser));
				end else begin
					want = expected_digest.pop_front();
					if (m_axis_tdata !== want.word)
						report_mismatch($sformatf("digest word %0d: got %h, want %h",
							want.index, m_axis_tdata, want.word));
					if (m_axis_tuser !== want.index)
						report_mismatch($sformatf("word index: got %0d, want %0d",
							m_axis_tuser, want.index));
					if (m_axis_tlast !== want.closing)
						report_mismatch($sformatf("last flag on word %0d: got %b, want %b",
							want.index, m_axis_tlast, want.closing));
				end
			end
			outstanding = expected_digest.size();
		end
	end

endmodule

/* bench/sha512_hash_engine_test.sv */
`timescale 1ns / 1ps
// Top of the SHA-512 hash engine testbench: clock, reset, message stimulus and verdict.
module sha512_hash_engine_test
	import sha512_pkg::*;
();

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [WORD_W-1:0] s_axis_tdata;   // [63:0] data_word
	logic [3:0]        s_axis_tuser;   // [3:0] valid_bytes
	logic              s_axis_tlast;   // last_word
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [WORD_W-1:0] m_axis_tdata;   // [63:0] digest_word
	logic [2:0]        m_axis_tuser;   // [2:0] word_index
	logic              m_axis_tlast;   // last_result

	int fail_count;
	int outstanding;

	// Stimulus bookkeeping: the count of accepted input transactions drives the
	// idling phases, and the percentages are read by the two driving processes.
	int items_sent;
	int send_gap_pct;
	int sink_stall_pct;
	bit hold_request;

	sha512_hash_engine DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// The checker sits beside the block, watches both channels and counts failures.
	sha512_digest_checker digest_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Mostly random bytes, with the all-zero and all-one words now and then.
	function automatic logic [63:0] random_word();
		case ($urandom_range(0, 9))
			0: return 64'd0;
			1: return ~64'd0;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Offer one word and hold it until the block takes it. Random gaps go in
	// front of the offer; tvalid is only ever assigned once per clock edge.
	task automatic send_word(input logic [63:0] data, input logic [3:0] nbytes,
			input logic tail);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= nbytes;
		s_axis_tlast  <= tail;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
		// Swap the idling sides, then run flat out with one long output stall.
		if (items_sent == 35) begin
			send_gap_pct   = 77;
			sink_stall_pct = 26;
		end else if (items_sent == 65) begin
			send_gap_pct   = 0;
			sink_stall_pct = 0;
			hold_request   = 1'b1;
		end
	endtask

	// One message: body words (tuser on them must be ignored), then the closing word.
	task automatic send_message(input int body_words, input logic [3:0] tail_bytes);
		for (int i = 0; i < body_words; i++)
			send_word(random_word(), 4'($urandom_range(0, 15)), 1'b0);
		send_word(random_word(), tail_bytes, 1'b1);
	endtask

	// Output side: random back-pressure, plus one long hold-off counted here
	// while the sender keeps offering, so the block fills and drops s_axis_tready.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				for (int hold_left = 400; hold_left > 0; hold_left--)
					@(posedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
			end
		end
	end

	initial begin
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = '0;
		s_axis_tlast   = 1'b0;
		arst_n         = 1'b0;
		items_sent     = 0;
		send_gap_pct   = 26;
		sink_stall_pct = 77;
		hold_request   = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty message, with junk in the ignored bytes of the closing word.
		send_word(~64'd0, 4'd0, 1'b1);
		// Closing word full: the 0x80 marker spills into a word of its own.
		send_word(~64'd0, 4'd8, 1'b1);
		// Single valid byte of zero.
		send_word(64'd0, 4'd1, 1'b1);
		// Non-closing word with tuser at its top value, then a count above eight.
		send_word(~64'd0, 4'd15, 1'b0);
		send_word(64'h0123456789abcdef, 4'd9, 1'b1);
		// Message ends before its closing word.
		send_message(3, 4'd0);
		// Closing word lands in slot fourteen, so the length needs a second block.
		send_message(14, 4'd7);

		// Random messages: mostly short, a share spanning two to three blocks.
		while (items_sent < 100)
			send_message(($urandom_range(0, 3) == 0) ? $urandom_range(14, 33)
				: $urandom_range(0, 15),
				4'(($urandom_range(0, 4) == 0) ? $urandom_range(9, 15)
				: $urandom_range(0, 8)));
		s_axis_tvalid <= 1'b0;

		// Let the checker see the final transaction, drain the digests, then
		// watch a little longer for any stray output.
		@(posedge clk);
		wait (outstanding == 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
